// File: rtl/mpq_pkg.sv
// ----------------------------------------------------------------------------
// mpq_pkg
// Shared types and constants for the linear-scan minimum priority queue.
// ----------------------------------------------------------------------------
package mpq_pkg;

  localparam int DATA_W       = 32;
  localparam int CMD_W        = 2;
  localparam int STATUS_W     = 2;
  localparam int OCC_W        = 8;
  localparam int CAPACITY_DEF = 128;

  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_DELETE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_PEEK   = 2'd2;

  localparam logic [STATUS_W-1:0] ST_INSERTED = 2'd0;
  localparam logic [STATUS_W-1:0] ST_MINIMUM  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FULL     = 2'd3;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT
  } mpq_state_t;

  // Control from the sequencer to the minimum tracker
  typedef struct packed {
    logic valid;
    logic first;
  } mpq_cmp_ctrl_t;

endpackage

// File: rtl/mpq_ram.sv
// ----------------------------------------------------------------------------
// mpq_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module mpq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: rtl/mpq_best.sv
// ----------------------------------------------------------------------------
// mpq_best
// Running minimum tracker: one signed comparator shared by every scan step.
// ----------------------------------------------------------------------------
module mpq_best #(
  parameter int IW = 8
) (
  input  logic                          clk,
  input  mpq_pkg::mpq_cmp_ctrl_t        ctrl,
  input  logic [IW-1:0]                 idx,
  input  logic [mpq_pkg::DATA_W-1:0]    data,
  output logic [mpq_pkg::DATA_W-1:0]    best_val,
  output logic [IW-1:0]                 best_idx,
  output logic [mpq_pkg::DATA_W-1:0]    upd_val,
  output logic [IW-1:0]                 upd_idx
);

  import mpq_pkg::*;

  logic take;

  // Strict less-than keeps the earliest entry on ties
  assign take    = ctrl.valid && (ctrl.first || ($signed(data) < $signed(best_val)));
  assign upd_val = take ? data : best_val;
  assign upd_idx = take ? idx : best_idx;

  always_ff @(posedge clk) begin
    best_val <= upd_val;
    best_idx <= upd_idx;
  end

endmodule

// File: rtl/min_priority_queue_linear_scan.sv
// ----------------------------------------------------------------------------
// min_priority_queue_linear_scan
// Minimum priority queue kept in arrival order, searched by a linear scan.
// ----------------------------------------------------------------------------
// Usage:
//   A command transfers on a clock edge where start is high and busy is low.
//   command selects insert, delete minimum or peek minimum (code 3 acts as a
//   peek); new_value is used by insert only. Every command gives exactly one
//   result: done is high for one cycle with status, min_value and occupancy.
//   The receiver cannot stall; results must be taken when done is high.
// Timing:
//   insert, full store, empty store : result in the cycle after the transfer.
//   peek                            : a scan reads and compares every stored entry.
//   delete                          : the same scan, then a pass that moves the
//                                     later entries down a place when needed.
//   The single read port of the entry RAM sets the pace: one entry is read and
//   compared, or moved, per cycle.
// Reset (rst, synchronous) empties the queue; the RAM contents
// are not cleared since only entries below the count are ever read.
// ----------------------------------------------------------------------------
module min_priority_queue_linear_scan #(
  parameter int CAPACITY = mpq_pkg::CAPACITY_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  output logic                               busy,
  input  logic [mpq_pkg::CMD_W-1:0]          command,
  input  logic signed [mpq_pkg::DATA_W-1:0]  new_value,
  output logic                               done,
  output logic [mpq_pkg::STATUS_W-1:0]       status,
  output logic signed [mpq_pkg::DATA_W-1:0]  min_value,
  output logic [mpq_pkg::OCC_W-1:0]          occupancy
);

  import mpq_pkg::*;

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  mpq_state_t state, state_next;

  logic [CW-1:0] count, count_next, count_m1;
  logic [CW-1:0] issue, shift_start, shift_dst, pipe_idx;
  logic          issue_act, pipe_valid, is_del, last_pipe;
  logic          launch_scan, launch_shift;

  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  logic [DATA_W-1:0] wr_data;
  logic [DATA_W-1:0] rd_data;

  logic                resp_en;
  logic [STATUS_W-1:0] resp_status;
  logic [DATA_W-1:0]   resp_min;
  logic [CW-1:0]       resp_occ;

  mpq_cmp_ctrl_t     cmp_ctrl;
  logic [DATA_W-1:0] best_val, upd_val;
  logic [CW-1:0]     best_idx, upd_idx;

  assign busy        = (state != S_IDLE);
  assign count_m1    = count - CW'(1);
  assign last_pipe   = pipe_valid && (pipe_idx == count_m1);
  assign shift_start = upd_idx + CW'(1);
  assign shift_dst   = pipe_idx - CW'(1);

  assign cmp_ctrl.valid = pipe_valid && (state == S_SCAN);
  assign cmp_ctrl.first = (pipe_idx == '0);

  mpq_ram #(
    .WIDTH (DATA_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (issue_act),
    .rd_addr (issue[AW-1:0]),
    .rd_data (rd_data)
  );

  mpq_best #(
    .IW (CW)
  ) u_best (
    .clk      (clk),
    .ctrl     (cmp_ctrl),
    .idx      (pipe_idx),
    .data     (rd_data),
    .best_val (best_val),
    .best_idx (best_idx),
    .upd_val  (upd_val),
    .upd_idx  (upd_idx)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next   = state;
    count_next   = count;
    wr_en        = 1'b0;
    wr_addr      = count[AW-1:0];
    wr_data      = new_value;
    launch_scan  = 1'b0;
    launch_shift = 1'b0;
    resp_en      = 1'b0;
    resp_status  = ST_MINIMUM;
    resp_min     = '0;
    resp_occ     = count;
    case (state)
      S_IDLE: begin
        if (start) begin
          if (command == CMD_INSERT) begin
            resp_en = 1'b1;
            if (count == CW'(CAPACITY)) begin
              resp_status = ST_FULL;
            end else begin
              wr_en       = 1'b1;
              count_next  = count + CW'(1);
              resp_status = ST_INSERTED;
              resp_occ    = count + CW'(1);
            end
          end else if (count == '0) begin
            resp_en     = 1'b1;
            resp_status = ST_EMPTY;
          end else begin
            launch_scan = 1'b1;
            state_next  = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (last_pipe) begin
          if (!is_del) begin
            resp_en    = 1'b1;
            resp_min   = upd_val;
            state_next = S_IDLE;
          end else if (upd_idx == count_m1) begin
            // minimum is the last entry: nothing to move
            resp_en    = 1'b1;
            resp_min   = upd_val;
            resp_occ   = count_m1;
            count_next = count_m1;
            state_next = S_IDLE;
          end else begin
            launch_shift = 1'b1;
            state_next   = S_SHIFT;
          end
        end
      end
      S_SHIFT: begin
        // move each entry read last cycle down one place
        if (pipe_valid) begin
          wr_en   = 1'b1;
          wr_addr = shift_dst[AW-1:0];
          wr_data = rd_data;
        end
        if (last_pipe) begin
          resp_en    = 1'b1;
          resp_min   = best_val;
          resp_occ   = count_m1;
          count_next = count_m1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count      <= '0;
      issue_act  <= 1'b0;
      pipe_valid <= 1'b0;
      done       <= 1'b0;
    end else begin
      count      <= count_next;
      pipe_valid <= issue_act;
      done       <= resp_en;
      if (launch_scan) begin
        issue     <= '0;
        issue_act <= 1'b1;
      end else if (launch_shift) begin
        issue     <= shift_start;
        issue_act <= 1'b1;
      end else if (issue_act) begin
        if (issue == count_m1) begin
          issue_act <= 1'b0;
        end else begin
          issue <= issue + CW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    pipe_idx <= issue;
    if (launch_scan) begin
      is_del <= (command == CMD_DELETE);
    end
    if (resp_en) begin
      status    <= resp_status;
      min_value <= resp_min;
      occupancy <= OCC_W'(resp_occ);
    end
  end

endmodule

// File: rtl/mpq_chk.sv
// ----------------------------------------------------------------------------
// mpq_chk
// Port-level checks for the minimum priority queue, bound to the top level.
// ----------------------------------------------------------------------------
module mpq_chk (
  input logic                               clk,
  input logic                               rst,
  input logic                               start,
  input logic                               busy,
  input logic [mpq_pkg::CMD_W-1:0]          command,
  input logic signed [mpq_pkg::DATA_W-1:0]  new_value,
  input logic                               done,
  input logic [mpq_pkg::STATUS_W-1:0]       status,
  input logic signed [mpq_pkg::DATA_W-1:0]  min_value,
  input logic [mpq_pkg::OCC_W-1:0]          occupancy
);

  import mpq_pkg::*;

  // Reset leaves the block idle with no result pending
  a_reset_idle: assert property (@(posedge clk) rst |=> (!busy && !done))
    else $error("block not idle after reset");

  // Insert always answers in the next cycle
  a_insert_fast: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && command == CMD_INSERT) |=>
      (done && (status == ST_INSERTED || status == ST_FULL)))
    else $error("insert result not in the following cycle");

  // Only a returned minimum carries a value
  a_min_zero: assert property (@(posedge clk) disable iff (rst)
    (done && status != ST_MINIMUM) |-> (min_value == '0))
    else $error("min_value not zero without a minimum");

  a_empty_occ: assert property (@(posedge clk) disable iff (rst)
    (done && status == ST_EMPTY) |-> (occupancy == '0))
    else $error("empty status with nonzero occupancy");

  // A result closes the command: the block is ready again
  a_done_ready: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result strobe while still busy");

endmodule

bind min_priority_queue_linear_scan mpq_chk u_mpq_chk (.*);
